FILE: rtl/lmbma_pkg.sv
package lmbma_pkg;

   localparam int MAX_SIDE   = 1024;
   localparam int COL_W      = $clog2(MAX_SIDE);
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int ROW_W      = $clog2(MAX_SIDE + 2);
   localparam int RING_DEPTH = MAX_SIDE + 1;
   localparam int RING_W     = $clog2(RING_DEPTH);
   localparam int PIX_W      = 8;
   localparam int MEAN_W     = 8;
   localparam int POS_W      = 10;
   localparam int SQ_W       = 2 * SIDE_W;
   localparam int SUM_W      = SQ_W + PIX_W;

   localparam int CFG_SIDE_W = 11;
   localparam int REG_IDX_W  = 1;
   localparam int ADDR_W     = 2 + REG_IDX_W;
   localparam int DATA_W     = 32;

   localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_SIDE   = 1'b1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PIX_W-1:0] pixel_value;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0]  bordered_pixel;
      logic [PIX_W-1:0]  inverted_pixel;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_column;
      logic              last_of_image;
      logic [MEAN_W-1:0] mean_level;
   } rsp_item_type;

endpackage

FILE: rtl/level_match_border_mark_average_core.sv
// Streams a square image in raster order and marks with 255 every pixel that has a matched
// neighbour (value 0, 255 or the target level), giving each result with its inverse and
// position; results run side+1 requests behind, so side+1 drain requests finish an image.
// A request is accepted in ST_IDLE while the match line memory and the pixel ring memory are
// read; ST_EXEC computes and writes both back. The final pixel of an image also passes through
// the bit-serial mean divider, which gives its mean level, before it is shown. A result waits
// in an output register; a request that would produce a result while that register is still
// full is held in ST_EXEC. Writing image_side aborts the image in progress.
module level_match_border_mark_average_core
   import lmbma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_item_type      rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } state_type;

   localparam logic [8:0]            WIN_MASK   = 9'h1EF;
   localparam logic [PIX_W-1:0]      PIX_MAX    = 8'd255;
   localparam logic [PIX_W-1:0]      PIX_MIN    = 8'd0;
   localparam logic [CFG_SIDE_W-1:0] SIDE_RESET = 11'd1000;
   localparam int                    MIN_SIDE   = 3;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (32'(v) > MAX_SIDE) begin
         r = SIDE_W'(MAX_SIDE);
      end else if (32'(v) < MIN_SIDE) begin
         r = SIDE_W'(MIN_SIDE);
      end else begin
         r = SIDE_W'(v);
      end
      return r;
   endfunction

   localparam logic [SIDE_W-1:0] S_RESET  = clamp_side(SIDE_RESET);
   localparam logic [SQ_W-1:0]   SQ_RESET = SQ_W'(S_RESET) * SQ_W'(S_RESET);

   state_type              state_ff, state_in;
   logic [PIX_W-1:0]       target_ff, target_in;
   logic [CFG_SIDE_W-1:0]  side_ff, side_in;
   logic [SIDE_W-1:0]      s_ff, s_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [ROW_W-1:0]       in_r_ff, in_r_in;
   logic [COL_W-1:0]       in_c_ff, in_c_in;
   logic [COL_W-1:0]       out_r_ff, out_r_in;
   logic [COL_W-1:0]       out_c_ff, out_c_in;
   logic [RING_W-1:0]      ring_ff, ring_in;
   logic [8:0]             win_ff, win_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   req_item_type           item_ff, item_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [1:0]             m_rd_data, m_wr_data;
   logic                   m_wr_en;
   logic [PIX_W-1:0]       p_rd_data;
   logic                   p_wr_en;
   logic                   div_start, div_done;
   logic [MEAN_W-1:0]      div_q;

   logic                   cfg_wr;
   logic [ROW_W-1:0]       s_row;
   logic [COL_W-1:0]       s_m1;
   logic                   in_image, is_drain, top_ok, mid_ok;
   logic                   top, mid, bot, bank, c_zero, emit, last, slot_free;
   logic [2:0]             col;
   logic [8:0]             win, win_next;
   logic [PIX_W-1:0]       pix, bordered;
   logic [SUM_W-1:0]       sum_next;

   lmbma_ram #(.WIDTH(2), .DEPTH(MAX_SIDE)) u_match_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (in_c_ff),
      .wr_data (m_wr_data),
      .rd_addr (in_c_ff),
      .rd_data (m_rd_data)
   );

   lmbma_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (ring_ff),
      .wr_data (pix),
      .rd_addr (ring_ff),
      .rd_data (p_rd_data)
   );

   lmbma_mean_div u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (sq_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      s_row    = ROW_W'(s_ff);
      s_m1     = COL_W'(s_ff - SIDE_W'(1));
      is_drain = item_ff.req_type == REQ_DRAIN;
      pix      = item_ff.pixel_value;
      in_image = in_r_ff < s_row;
      bot      = in_image && (pix == PIX_MIN || pix == PIX_MAX || pix == target_ff);
      top_ok   = (in_r_ff >= ROW_W'(2)) && ((in_r_ff - ROW_W'(2)) < s_row);
      mid_ok   = (in_r_ff >= ROW_W'(1)) && ((in_r_ff - ROW_W'(1)) < s_row);
      bank     = in_r_ff[0];
      top      = top_ok && m_rd_data[bank];
      mid      = mid_ok && m_rd_data[~bank];
      col      = {bot, mid, top};
      c_zero   = in_c_ff == '0;
      if (c_zero) begin
         win      = {3'b000, win_ff[8:3]};
         win_next = {col, 6'b000000};
      end else begin
         win_next = {col, win_ff[8:3]};
         win      = win_next;
      end
      emit      = (in_r_ff >= ROW_W'(2)) || (in_r_ff == ROW_W'(1) && !c_zero);
      bordered  = (|(win & WIN_MASK)) ? PIX_MAX : p_rd_data;
      last      = (out_r_ff == s_m1) && (out_c_ff == s_m1);
      sum_next  = sum_ff + SUM_W'(bordered);
      slot_free = !rsp_valid_ff || rsp_ready;
      m_wr_data = m_rd_data;
      m_wr_data[bank] = bot;
   end

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      side_in      = side_ff;
      sq_in        = SQ_W'(s_ff) * SQ_W'(s_ff);
      in_r_in      = in_r_ff;
      in_c_in      = in_c_ff;
      out_r_in     = out_r_ff;
      out_c_in     = out_c_ff;
      ring_in      = ring_ff;
      win_in       = win_ff;
      sum_in       = sum_ff;
      item_in      = item_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      m_wr_en      = 1'b0;
      p_wr_en      = 1'b0;
      div_start    = 1'b0;
      cfg_wr       = psel && penable && pwrite;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (in_image && is_drain) begin
               state_in = ST_IDLE;
            end else if (!emit || slot_free) begin
               m_wr_en  = in_image;
               p_wr_en  = in_image;
               win_in   = win_next;
               ring_in  = (ring_ff == RING_W'(s_ff)) ? '0 : ring_ff + RING_W'(1);
               if (in_c_ff == s_m1) begin
                  in_c_in = '0;
                  in_r_in = in_r_ff + ROW_W'(1);
               end else begin
                  in_c_in = in_c_ff + COL_W'(1);
               end
               state_in = ST_IDLE;
               if (emit) begin
                  rsp_item_in.bordered_pixel = bordered;
                  rsp_item_in.inverted_pixel = PIX_MAX - bordered;
                  rsp_item_in.out_row        = POS_W'(out_r_ff);
                  rsp_item_in.out_column     = POS_W'(out_c_ff);
                  rsp_item_in.last_of_image  = last;
                  rsp_item_in.mean_level     = '0;
                  if (last) begin
                     div_start = 1'b1;
                     in_r_in   = '0;
                     in_c_in   = '0;
                     out_r_in  = '0;
                     out_c_in  = '0;
                     ring_in   = '0;
                     win_in    = '0;
                     sum_in    = '0;
                     state_in  = ST_DIV;
                  end else begin
                     rsp_valid_in = 1'b1;
                     sum_in       = sum_next;
                     if (out_c_ff == s_m1) begin
                        out_c_in = '0;
                        out_r_in = out_r_ff + COL_W'(1);
                     end else begin
                        out_c_in = out_c_ff + COL_W'(1);
                     end
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_item_in.mean_level = div_q;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         case (paddr[ADDR_W-1:2])
            REG_TARGET: begin
               target_in = pwdata[PIX_W-1:0];
            end
            REG_SIDE: begin
               side_in  = pwdata[CFG_SIDE_W-1:0];
               in_r_in  = '0;
               in_c_in  = '0;
               out_r_in = '0;
               out_c_in = '0;
               ring_in  = '0;
               win_in   = '0;
               sum_in   = '0;
            end
            default: begin
               target_in = target_ff;
            end
         endcase
      end

      s_in = clamp_side(side_in);
   end

   always_comb begin
      case (paddr[ADDR_W-1:2])
         REG_TARGET: prdata = DATA_W'(target_ff);
         REG_SIDE:   prdata = DATA_W'(side_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         side_ff      <= SIDE_RESET;
         s_ff         <= S_RESET;
         sq_ff        <= SQ_RESET;
         in_r_ff      <= '0;
         in_c_ff      <= '0;
         out_r_ff     <= '0;
         out_c_ff     <= '0;
         ring_ff      <= '0;
         win_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         side_ff      <= side_in;
         s_ff         <= s_in;
         sq_ff        <= sq_in;
         in_r_ff      <= in_r_in;
         in_c_ff      <= in_c_in;
         out_r_ff     <= out_r_in;
         out_c_ff     <= out_c_in;
         ring_ff      <= ring_in;
         win_ff       <= win_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign pready    = 1'b1;

`ifndef ASSERT_OFF
   a_div_slot_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !rsp_valid_ff)
      else $error("Output register occupied while the mean is being divided.");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.last_of_image |-> out_r_ff == '0 && out_c_ff == '0)
      else $error("Output position not cleared after the final pixel.");

   a_pointers_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> ring_ff <= RING_W'(s_ff) && SIDE_W'(in_c_ff) < s_ff)
      else $error("Ring pointer or input column beyond the image side.");
`endif

endmodule

FILE: rtl/lmbma_ram.sv
module lmbma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lmbma_mean_div.sv
module lmbma_mean_div
   import lmbma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [SQ_W-1:0]   divisor,
   output logic              done,
   output logic [MEAN_W-1:0] quotient
);

   localparam int CNT_W = $clog2(MEAN_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;
   logic [MEAN_W-1:0] quo_ff, quo_in;
   logic              fits;

   always_comb begin
      fits    = rem_ff >= dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dvs_in  = SUM_W'(divisor) << (MEAN_W - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dvs_ff;
         end
         quo_in = {quo_ff[MEAN_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MEAN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
